// ===== sv/assert_macros.svh =====
// Assertion macros for the heap queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/hmq_pkg.sv =====
// Package for the heap queue: item types, codes and default sizes.
`default_nettype none

package hmq_pkg;

  localparam int KEY_W          = 32;
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 16;

  localparam logic [6:0] MAX_ENTRIES_RST = 7'd64;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [15:0]      payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [15:0] data_out;
    logic [6:0]  occupancy;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/binary_min_heap_queue.sv =====
// Top level of the heap queue: command FSM, sift engine and result register.
// Full insert / empty extract: result strobes in the cycle after accept, busy stays low.
// Insert: busy through ST_UP while it climbs, then ST_FIN; an insert into an empty heap goes to ST_FIN.
// Extract: busy through ST_LOAD, ST_DOWN while it descends, then ST_FIN; taking the last entry ends in ST_LOAD.
// Result strobes in the first cycle busy is low; a new command is taken only while busy is low.
// Receiver cannot stall. Sync reset (rst_n low) clears count, FSM, strobe; max_entries = 64.
`default_nettype none

`include "assert_macros.svh"

module binary_min_heap_queue #(
  parameter int DEPTH      = hmq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = hmq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire hmq_pkg::in_item_t in_data,
  // result channel, cannot be stalled
  output logic                   out_strobe,
  output hmq_pkg::out_item_t     out_item,
  // capacity register write
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [6:0]        cfg_data
);
  import hmq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // FSM codes
  localparam logic [2:0] ST_IDLE = 3'd0; // wait for a command
  localparam logic [2:0] ST_UP   = 3'd1; // sift-up: compare parent, move it down
  localparam logic [2:0] ST_LOAD = 3'd2; // extract: root and last entry arrive
  localparam logic [2:0] ST_DOWN = 3'd3; // sift-down: compare children, move one up
  localparam logic [2:0] ST_FIN  = 3'd4; // drop the moving entry into the hole

  logic [2:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         hole_r, hole_nxt;
  logic [KEY_W-1:0]      ent_key_r, ent_key_nxt;
  logic [DATA_WIDTH-1:0] ent_pay_r, ent_pay_nxt;
  logic                  op_r, op_nxt;
  logic [15:0]           data_r, data_nxt;
  logic [6:0]            max_entries_r;
  logic                  out_strobe_r, out_strobe_nxt;
  out_item_t             out_r, out_nxt;

  // memory ports
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [KEY_W-1:0]      mem_wr_key;
  logic [DATA_WIDTH-1:0] mem_wr_pay;
  logic [AW-1:0]         mem_rd_addr_a, mem_rd_addr_b;
  logic [KEY_W-1:0]      mem_rd_key_a, mem_rd_key_b;
  logic [DATA_WIDTH-1:0] mem_rd_pay_a, mem_rd_pay_b;

  // assertion terms
  logic                  ext_on_empty, res_empty, res_refused;

  hmq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_key    (mem_wr_key),
    .wr_pay    (mem_wr_pay),
    .rd_addr_a (mem_rd_addr_a),
    .rd_addr_b (mem_rd_addr_b),
    .rd_key_a  (mem_rd_key_a),
    .rd_pay_a  (mem_rd_pay_a),
    .rd_key_b  (mem_rd_key_b),
    .rd_pay_b  (mem_rd_pay_b)
  );

  // 32-bit views keep index math and truncation explicit
  logic [31:0] cnt32, hole32, par32, gpar32, last32, lpar32;
  logic [31:0] l32, r32, s32, sl32, sr32, cap32;
  logic [63:0] pay_in64, pay_a64;
  logic        full, l_ok, r_ok, take_l, take_r;
  logic [KEY_W-1:0] min_key;

  always_comb begin
    cnt32    = 32'(count_r);
    hole32   = 32'(hole_r);
    par32    = (hole32 - 32'd1) >> 1;
    gpar32   = (par32 - 32'd1) >> 1;
    last32   = cnt32 - 32'd1;
    lpar32   = (cnt32 - 32'd1) >> 1;
    l32      = (hole32 << 1) + 32'd1;
    r32      = (hole32 << 1) + 32'd2;
    // capacity in force is max_entries capped at DEPTH
    cap32    = (32'(max_entries_r) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(max_entries_r);
    full     = cnt32 >= cap32;
    pay_in64 = 64'(in_data.payload);
    pay_a64  = 64'(mem_rd_pay_a);
    // sift-down choice: left wins ties, right only if strictly smaller
    l_ok     = l32 < cnt32;
    r_ok     = r32 < cnt32;
    take_l   = l_ok && (mem_rd_key_a < ent_key_r);
    min_key  = take_l ? mem_rd_key_a : ent_key_r;
    take_r   = r_ok && (mem_rd_key_b < min_key);
    s32      = take_r ? r32 : l32;
    sl32     = (s32 << 1) + 32'd1;
    sr32     = (s32 << 1) + 32'd2;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    hole_nxt       = hole_r;
    ent_key_nxt    = ent_key_r;
    ent_pay_nxt    = ent_pay_r;
    op_nxt         = op_r;
    data_nxt       = data_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = hole_r;
    mem_wr_key     = ent_key_r;
    mem_wr_pay     = ent_pay_r;
    mem_rd_addr_a  = '0;
    mem_rd_addr_b  = '0;

    case (state_r)
      ST_IDLE: begin
        // insert reads the parent of the free slot; extract reads root and last
        mem_rd_addr_a = (in_data.cmd == CMD_INSERT) ? lpar32[AW-1:0] : '0;
        mem_rd_addr_b = last32[AW-1:0];
        if (start) begin
          op_nxt = in_data.cmd;
          if (in_data.cmd == CMD_INSERT) begin
            if (full) begin
              out_strobe_nxt    = 1'b1;
              out_nxt.status    = STAT_FULL;
              out_nxt.slot      = '0;
              out_nxt.data_out  = '0;
              out_nxt.occupancy = cnt32[6:0];
            end else begin
              ent_key_nxt = in_data.key;
              ent_pay_nxt = pay_in64[DATA_WIDTH-1:0];
              hole_nxt    = cnt32[AW-1:0];
              count_nxt   = count_r + CW'(1);
              state_nxt   = (count_r == '0) ? ST_FIN : ST_UP;
            end
          end else begin
            if (count_r == '0) begin
              out_strobe_nxt    = 1'b1;
              out_nxt.status    = STAT_EMPTY;
              out_nxt.slot      = '0;
              out_nxt.data_out  = '0;
              out_nxt.occupancy = cnt32[6:0];
            end else begin
              count_nxt = count_r - CW'(1);
              hole_nxt  = '0;
              state_nxt = ST_LOAD;
            end
          end
        end
      end

      ST_UP: begin
        // prefetch the grandparent while the parent compare resolves
        mem_rd_addr_a = gpar32[AW-1:0];
        if (mem_rd_key_a > ent_key_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_key  = mem_rd_key_a;
          mem_wr_pay  = mem_rd_pay_a;
          hole_nxt    = par32[AW-1:0];
          if (par32 == 32'd0) begin
            state_nxt = ST_FIN;
          end
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_LOAD: begin
        data_nxt      = pay_a64[15:0];
        ent_key_nxt   = mem_rd_key_b;
        ent_pay_nxt   = mem_rd_pay_b;
        mem_rd_addr_a = l32[AW-1:0];
        mem_rd_addr_b = r32[AW-1:0];
        if (count_r == '0) begin
          // last entry was the root: nothing to sift
          out_strobe_nxt    = 1'b1;
          out_nxt.status    = STAT_OK;
          out_nxt.slot      = '0;
          out_nxt.data_out  = pay_a64[15:0];
          out_nxt.occupancy = cnt32[6:0];
          state_nxt         = ST_IDLE;
        end else begin
          state_nxt = ST_DOWN;
        end
      end

      ST_DOWN: begin
        mem_rd_addr_a = sl32[AW-1:0];
        mem_rd_addr_b = sr32[AW-1:0];
        if (take_r) begin
          mem_wr_en  = 1'b1;
          mem_wr_key = mem_rd_key_b;
          mem_wr_pay = mem_rd_pay_b;
          hole_nxt   = r32[AW-1:0];
        end else if (take_l) begin
          mem_wr_en  = 1'b1;
          mem_wr_key = mem_rd_key_a;
          mem_wr_pay = mem_rd_pay_a;
          hole_nxt   = l32[AW-1:0];
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        mem_wr_en         = 1'b1;
        out_strobe_nxt    = 1'b1;
        out_nxt.status    = STAT_OK;
        out_nxt.slot      = (op_r == CMD_INSERT) ? hole32[5:0] : 6'd0;
        out_nxt.data_out  = (op_r == CMD_EXTRACT) ? data_r : 16'd0;
        out_nxt.occupancy = cnt32[6:0];
        state_nxt         = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      out_strobe_r  <= 1'b0;
      max_entries_r <= MAX_ENTRIES_RST;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        max_entries_r <= cfg_data;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    hole_r    <= hole_nxt;
    ent_key_r <= ent_key_nxt;
    ent_pay_r <= ent_pay_nxt;
    op_r      <= op_nxt;
    data_r    <= data_nxt;
    out_r     <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  assign ext_on_empty = start && !busy && (in_data.cmd == CMD_EXTRACT) && (count_r == '0);
  assign res_empty    = out_strobe && (out_item.status == STAT_EMPTY);
  assign res_refused  = out_strobe && (out_item.status != STAT_OK);

  `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, cnt32 <= 32'(DEPTH), "count above depth")
  `ASSERT_IMPLIES(a_wr_busy, clk, rst_n, mem_wr_en, state_r != ST_IDLE, "heap write while idle")
  `ASSERT_NEXT(a_empty_resp, clk, rst_n, ext_on_empty, res_empty, "empty extract not reported")
  `ASSERT_IMPLIES(a_err_hold, clk, rst_n, res_refused, $stable(count_r), "refused item moved count")

endmodule

`default_nettype wire

// ===== sv/hmq_mem.sv =====
// Heap storage: key and payload arrays, one write port, two registered read ports.
`default_nettype none

module hmq_mem #(
  parameter int DEPTH      = hmq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = hmq_pkg::DATA_WIDTH_DEF,
  parameter int AW         = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [hmq_pkg::KEY_W-1:0] wr_key,
  input  wire logic [DATA_WIDTH-1:0]     wr_pay,
  input  wire logic [AW-1:0]             rd_addr_a,
  input  wire logic [AW-1:0]             rd_addr_b,
  output logic      [hmq_pkg::KEY_W-1:0] rd_key_a,
  output logic      [DATA_WIDTH-1:0]     rd_pay_a,
  output logic      [hmq_pkg::KEY_W-1:0] rd_key_b,
  output logic      [DATA_WIDTH-1:0]     rd_pay_b
);
  import hmq_pkg::*;

  logic [KEY_W-1:0]      key_mem [DEPTH];
  logic [DATA_WIDTH-1:0] pay_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
  end

  always_ff @(posedge clk) begin
    rd_key_a <= key_mem[rd_addr_a];
    rd_pay_a <= pay_mem[rd_addr_a];
    rd_key_b <= key_mem[rd_addr_b];
    rd_pay_b <= pay_mem[rd_addr_b];
  end

endmodule

`default_nettype wire
